>>> sv/json_token_lexer_top_macros.svh
// assertion helpers used by the checker of this block
`ifndef JSON_TOKEN_LEXER_TOP_MACROS_SVH
`define JSON_TOKEN_LEXER_TOP_MACROS_SVH

// same-cycle implication, sampled on the block clock, off during reset
`define JTL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("jtl check failed");

// next-cycle implication, sampled on the block clock, off during reset
`define JTL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jtl check failed");

`endif

>>> sv/jtl_pkg.sv
package jtl_pkg;

  localparam int unsigned DOC_BYTES  = 1048576;
  // offsets, lines and columns must hold DOC_BYTES itself
  localparam int unsigned POS_W      = $clog2(DOC_BYTES) + 1;
  localparam int unsigned START_W    = 20;
  // largest value of the length, line and column outputs
  localparam int unsigned FIELD_MAX  = 1048576;
  localparam int unsigned MAX_TOKENS = 3;
  localparam int unsigned TOK_CNT_W  = $clog2(MAX_TOKENS + 1);
  localparam int unsigned Q_DEPTH    = 4;
  localparam int unsigned Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W    = $clog2(Q_DEPTH + 1);

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [3:0] {
    TK_LBRACE   = 4'd0,
    TK_RBRACE   = 4'd1,
    TK_LBRACKET = 4'd2,
    TK_RBRACKET = 4'd3,
    TK_COLON    = 4'd4,
    TK_COMMA    = 4'd5,
    TK_STRING   = 4'd6,
    TK_INTEGER  = 4'd7,
    TK_NUMBER   = 4'd8,
    TK_NULL     = 4'd9,
    TK_TRUE     = 4'd10,
    TK_FALSE    = 4'd11,
    TK_END      = 4'd12,
    TK_ERROR    = 4'd13
  } tok_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_BAD_ESCAPE  = 3'd1,
    ERR_SHORT_UNI   = 3'd2,
    ERR_UNTERM_STR  = 3'd3,
    ERR_BAD_WORD    = 3'd4,
    ERR_BAD_START   = 3'd5
  } err_e;

  typedef struct packed {
    tok_kind_e          kind;
    logic [START_W-1:0] start;
    pos_t               length;
    pos_t               line;
    pos_t               column;
    err_e               err;
    logic               last;
  } token_t;

  typedef struct packed {
    logic [TOK_CNT_W-1:0]          count;
    token_t [MAX_TOKENS-1:0]       tok;
  } push_t;

endpackage

>>> sv/jtl_fifo.sv
module jtl_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  jtl_pkg::push_t  push_i,
  output logic            room_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output jtl_pkg::token_t head_o
);

  jtl_pkg::token_t                    mem_q [jtl_pkg::Q_DEPTH];
  logic [jtl_pkg::Q_PTR_W-1:0]        wr_q, wr_d, rd_q, rd_d;
  logic [jtl_pkg::Q_CNT_W-1:0]        cnt_q, cnt_d;
  logic                               pop;

  assign out_valid_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  // a lexed byte may leave up to MAX_TOKENS tokens
  assign room_o      = cnt_q <= jtl_pkg::Q_CNT_W'(jtl_pkg::Q_DEPTH - jtl_pkg::MAX_TOKENS);

  always_comb begin
    wr_d  = wr_q + jtl_pkg::Q_PTR_W'(push_i.count);
    rd_d  = pop ? rd_q + jtl_pkg::Q_PTR_W'(1) : rd_q;
    cnt_d = cnt_q + jtl_pkg::Q_CNT_W'(push_i.count) - jtl_pkg::Q_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < jtl_pkg::MAX_TOKENS; k++) begin
      if (jtl_pkg::TOK_CNT_W'(k) < push_i.count) begin
        mem_q[wr_q + jtl_pkg::Q_PTR_W'(k)] <= push_i.tok[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> sv/jtl_core.sv
module jtl_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     data_byte_i,
  input  logic           end_of_document_i,
  input  logic           room_i,
  output jtl_pkg::push_t push_o
);

  typedef enum logic [4:0] {
    M_BETWEEN = 5'b00001,
    M_WORD    = 5'b00010,
    M_STRING  = 5'b00100,
    M_ESCAPE  = 5'b01000,
    M_UNICODE = 5'b10000
  } mode_e;

  typedef enum logic [8:0] {
    S_START = 9'b000000001,
    S_MINUS = 9'b000000010,
    S_INT   = 9'b000000100,
    S_DOT   = 9'b000001000,
    S_FRAC  = 9'b000010000,
    S_EXP   = 9'b000100000,
    S_ESIGN = 9'b001000000,
    S_EDIG  = 9'b010000000,
    S_BAD   = 9'b100000000
  } shape_e;

  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LO_E     = 8'h65;
  localparam logic [7:0] CH_UP_E     = 8'h45;
  localparam logic [7:0] CH_LO_U     = 8'h75;
  localparam logic [7:0] CH_LO_B     = 8'h62;
  localparam logic [7:0] CH_LO_F     = 8'h66;
  localparam logic [7:0] CH_LO_N     = 8'h6E;
  localparam logic [7:0] CH_LO_R     = 8'h72;
  localparam logic [7:0] CH_LO_T     = 8'h74;

  localparam int unsigned NULL_LEN  = 4;
  localparam int unsigned TRUE_LEN  = 4;
  localparam int unsigned FALSE_LEN = 5;
  localparam logic [7:0] KW_NULL  [NULL_LEN]  = '{8'h6E, 8'h75, 8'h6C, 8'h6C};
  localparam logic [7:0] KW_TRUE  [TRUE_LEN]  = '{8'h74, 8'h72, 8'h75, 8'h65};
  localparam logic [7:0] KW_FALSE [FALSE_LEN] = '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65};
  localparam int unsigned KB_NULL  = 0;
  localparam int unsigned KB_TRUE  = 1;
  localparam int unsigned KB_FALSE = 2;
  localparam logic [2:0]  KW_ALL   = 3'b111;

  localparam logic [1:0] HEX_LAST = 2'd3;

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= CH_LO_F) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_digit(c) || is_alpha(c) || c == CH_DOT || c == CH_MINUS;
  endfunction

  function automatic shape_e shape_next(shape_e s, logic [7:0] c);
    logic d;
    logic e;
    shape_e r;
    d = is_digit(c);
    e = (c == CH_LO_E) || (c == CH_UP_E);
    unique case (s)
      S_START: r = (c == CH_MINUS) ? S_MINUS : d ? S_INT : S_BAD;
      S_MINUS: r = d ? S_INT : S_BAD;
      S_INT:   r = d ? S_INT : (c == CH_DOT) ? S_DOT : e ? S_EXP : S_BAD;
      S_DOT:   r = d ? S_FRAC : S_BAD;
      S_FRAC:  r = d ? S_FRAC : e ? S_EXP : S_BAD;
      S_EXP:   r = (c == CH_MINUS) ? S_ESIGN : d ? S_EDIG : S_BAD;
      S_ESIGN: r = d ? S_EDIG : S_BAD;
      S_EDIG:  r = d ? S_EDIG : S_BAD;
      default: r = S_BAD;
    endcase
    return r;
  endfunction

  // drop every keyword that is too short for this word position or whose letter there differs
  function automatic logic [2:0] kw_next(logic [2:0] kw, jtl_pkg::pos_t pos, logic [7:0] c);
    logic [2:0] r;
    r = kw;
    if (!(pos < jtl_pkg::POS_W'(NULL_LEN) && c == KW_NULL[pos[1:0]])) r[KB_NULL] = 1'b0;
    if (!(pos < jtl_pkg::POS_W'(TRUE_LEN) && c == KW_TRUE[pos[1:0]])) r[KB_TRUE] = 1'b0;
    if (!(pos < jtl_pkg::POS_W'(FALSE_LEN) && c == KW_FALSE[pos[2:0]])) r[KB_FALSE] = 1'b0;
    return r;
  endfunction

  function automatic jtl_pkg::tok_kind_e word_kind(shape_e s, logic [2:0] kw,
                                                   jtl_pkg::pos_t len);
    jtl_pkg::tok_kind_e k;
    priority if (s == S_INT) k = jtl_pkg::TK_INTEGER;
    else if (s == S_FRAC || s == S_EDIG) k = jtl_pkg::TK_NUMBER;
    else if (kw[KB_NULL] && len == jtl_pkg::POS_W'(NULL_LEN)) k = jtl_pkg::TK_NULL;
    else if (kw[KB_FALSE] && len == jtl_pkg::POS_W'(FALSE_LEN)) k = jtl_pkg::TK_FALSE;
    else if (kw[KB_TRUE] && len == jtl_pkg::POS_W'(TRUE_LEN)) k = jtl_pkg::TK_TRUE;
    else k = jtl_pkg::TK_ERROR;
    return k;
  endfunction

  function automatic jtl_pkg::pos_t sat_inc(jtl_pkg::pos_t v);
    return (v < jtl_pkg::POS_W'(jtl_pkg::DOC_BYTES)) ? v + jtl_pkg::POS_W'(1) : v;
  endfunction

  function automatic jtl_pkg::pos_t clamp_field(jtl_pkg::pos_t v);
    return (v > jtl_pkg::POS_W'(jtl_pkg::FIELD_MAX)) ? jtl_pkg::POS_W'(jtl_pkg::FIELD_MAX) : v;
  endfunction

  function automatic jtl_pkg::token_t make_tok(jtl_pkg::tok_kind_e kind, jtl_pkg::pos_t start,
                                               jtl_pkg::pos_t len, jtl_pkg::pos_t line,
                                               jtl_pkg::pos_t col, jtl_pkg::err_e err);
    jtl_pkg::token_t t;
    t.kind   = kind;
    t.start  = (start[jtl_pkg::POS_W-1:jtl_pkg::START_W] != '0) ? '1
                                                              : start[jtl_pkg::START_W-1:0];
    // lengths, lines and columns above FIELD_MAX are clamped to it
    t.length = clamp_field(len);
    t.line   = clamp_field(line);
    t.column = clamp_field(col);
    t.err    = err;
    t.last   = 1'b0;
    return t;
  endfunction

  // input register
  logic       in_v_q;
  logic [7:0] byte_q;
  logic       eod_q;
  logic       process;

  // lexer state
  mode_e         mode_q, mode_d;
  logic [1:0]    hex_q, hex_d;
  shape_e        shape_q, shape_d;
  logic [2:0]    kw_q, kw_d;
  logic          halt_q, halt_d;
  jtl_pkg::pos_t boff_q, boff_d, soff_q, soff_d;
  jtl_pkg::pos_t line_q, line_d, col_q, col_d;
  jtl_pkg::pos_t sline_q, sline_d, scol_q, scol_d;

  jtl_pkg::token_t [jtl_pkg::MAX_TOKENS-1:0] toks;
  logic [jtl_pkg::TOK_CNT_W-1:0]            n;

  assign process    = in_v_q && room_i;
  assign in_ready_o = !in_v_q || process;

  always_comb begin
    logic                 between;
    logic                 is_delim;
    jtl_pkg::tok_kind_e   dkind;
    jtl_pkg::tok_kind_e   wkind;
    jtl_pkg::pos_t        wlen;

    mode_d   = mode_q;
    hex_d    = hex_q;
    shape_d  = shape_q;
    kw_d     = kw_q;
    halt_d   = halt_q;
    boff_d   = boff_q;
    soff_d   = soff_q;
    line_d   = line_q;
    col_d    = col_q;
    sline_d  = sline_q;
    scol_d   = scol_q;
    toks     = '0;
    n        = '0;
    between  = 1'b0;
    is_delim = 1'b1;
    dkind    = jtl_pkg::TK_LBRACE;
    wlen     = boff_q - soff_q;
    wkind    = word_kind(shape_q, kw_q, wlen);

    if (!halt_q) begin
      unique case (mode_q)
        M_WORD: begin
          if (is_word(byte_q)) begin
            shape_d = shape_next(shape_q, byte_q);
            kw_d    = kw_next(kw_q, wlen, byte_q);
          end else begin
            toks[n] = make_tok(wkind, soff_q, wlen, sline_q, scol_q,
                               (wkind == jtl_pkg::TK_ERROR) ? jtl_pkg::ERR_BAD_WORD
                                                           : jtl_pkg::ERR_NONE);
            n       = n + 1'b1;
            mode_d  = M_BETWEEN;
            if (wkind == jtl_pkg::TK_ERROR) halt_d = 1'b1;
            else between = 1'b1;
          end
        end
        M_STRING: begin
          if (byte_q == CH_QUOTE) begin
            toks[n] = make_tok(jtl_pkg::TK_STRING, soff_q, wlen + 1'b1, sline_q, scol_q,
                               jtl_pkg::ERR_NONE);
            n       = n + 1'b1;
            mode_d  = M_BETWEEN;
          end else if (byte_q == CH_BSLASH) begin
            mode_d = M_ESCAPE;
          end
        end
        M_ESCAPE: begin
          if (byte_q == CH_QUOTE || byte_q == CH_BSLASH || byte_q == CH_SLASH ||
              byte_q == CH_LO_B || byte_q == CH_LO_F || byte_q == CH_LO_N ||
              byte_q == CH_LO_R || byte_q == CH_LO_T) begin
            mode_d = M_STRING;
          end else if (byte_q == CH_LO_U) begin
            mode_d = M_UNICODE;
            hex_d  = '0;
          end else begin
            toks[n] = make_tok(jtl_pkg::TK_ERROR, soff_q, wlen + 1'b1, sline_q, scol_q,
                               jtl_pkg::ERR_BAD_ESCAPE);
            n       = n + 1'b1;
            halt_d  = 1'b1;
            mode_d  = M_BETWEEN;
          end
        end
        M_UNICODE: begin
          if (is_hex(byte_q)) begin
            if (hex_q == HEX_LAST) begin
              hex_d  = '0;
              mode_d = M_STRING;
            end else begin
              hex_d = hex_q + 1'b1;
            end
          end else begin
            toks[n] = make_tok(jtl_pkg::TK_ERROR, soff_q, wlen + 1'b1, sline_q, scol_q,
                               jtl_pkg::ERR_SHORT_UNI);
            n       = n + 1'b1;
            halt_d  = 1'b1;
            mode_d  = M_BETWEEN;
          end
        end
        default: begin
          mode_d  = M_BETWEEN;
          between = 1'b1;
        end
      endcase

      // the byte opens a new token
      if (between && !is_space(byte_q)) begin
        soff_d  = boff_q;
        sline_d = line_q;
        scol_d  = col_q;
        unique case (byte_q)
          CH_LBRACE:   dkind = jtl_pkg::TK_LBRACE;
          CH_RBRACE:   dkind = jtl_pkg::TK_RBRACE;
          CH_LBRACKET: dkind = jtl_pkg::TK_LBRACKET;
          CH_RBRACKET: dkind = jtl_pkg::TK_RBRACKET;
          CH_COLON:    dkind = jtl_pkg::TK_COLON;
          CH_COMMA:    dkind = jtl_pkg::TK_COMMA;
          default:     is_delim = 1'b0;
        endcase
        priority if (is_delim) begin
          toks[n] = make_tok(dkind, boff_q, jtl_pkg::POS_W'(1), line_q, col_q,
                             jtl_pkg::ERR_NONE);
          n       = n + 1'b1;
        end else if (byte_q == CH_QUOTE) begin
          mode_d = M_STRING;
        end else if (is_word(byte_q)) begin
          mode_d  = M_WORD;
          shape_d = shape_next(S_START, byte_q);
          kw_d    = kw_next(KW_ALL, '0, byte_q);
        end else begin
          toks[n] = make_tok(jtl_pkg::TK_ERROR, boff_q, jtl_pkg::POS_W'(1), line_q, col_q,
                             jtl_pkg::ERR_BAD_START);
          n       = n + 1'b1;
          halt_d  = 1'b1;
        end
      end

      boff_d = sat_inc(boff_q);
      if (byte_q == CH_LF) begin
        line_d = sat_inc(line_q);
        col_d  = jtl_pkg::POS_W'(1);
      end else begin
        col_d = sat_inc(col_q);
      end
    end

    if (eod_q) begin
      if (!halt_d) begin
        if (mode_d == M_WORD) begin
          wkind   = word_kind(shape_d, kw_d, boff_d - soff_d);
          toks[n] = make_tok(wkind, soff_d, boff_d - soff_d, sline_d, scol_d,
                             (wkind == jtl_pkg::TK_ERROR) ? jtl_pkg::ERR_BAD_WORD
                                                         : jtl_pkg::ERR_NONE);
          n       = n + 1'b1;
        end else if (mode_d != M_BETWEEN) begin
          toks[n] = make_tok(jtl_pkg::TK_ERROR, soff_d, boff_d - soff_d, sline_d, scol_d,
                             jtl_pkg::ERR_UNTERM_STR);
          n       = n + 1'b1;
        end
      end
      toks[n] = make_tok(jtl_pkg::TK_END, boff_d, '0, line_d, col_d, jtl_pkg::ERR_NONE);
      n       = n + 1'b1;
      mode_d  = M_BETWEEN;
      hex_d   = '0;
      shape_d = S_START;
      kw_d    = KW_ALL;
      halt_d  = 1'b0;
      boff_d  = '0;
      soff_d  = '0;
      line_d  = jtl_pkg::POS_W'(1);
      col_d   = jtl_pkg::POS_W'(1);
      sline_d = jtl_pkg::POS_W'(1);
      scol_d  = jtl_pkg::POS_W'(1);
    end

    if (n != '0) toks[n - 1'b1].last = 1'b1;
  end

  assign push_o.count = process ? n : '0;
  assign push_o.tok   = toks;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
      eod_q  <= end_of_document_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      mode_q  <= M_BETWEEN;
      hex_q   <= '0;
      shape_q <= S_START;
      kw_q    <= KW_ALL;
      halt_q  <= 1'b0;
      boff_q  <= '0;
      soff_q  <= '0;
      line_q  <= jtl_pkg::POS_W'(1);
      col_q   <= jtl_pkg::POS_W'(1);
      sline_q <= jtl_pkg::POS_W'(1);
      scol_q  <= jtl_pkg::POS_W'(1);
    end else begin
      if (in_ready_o) in_v_q <= in_valid_i;
      if (process) begin
        mode_q  <= mode_d;
        hex_q   <= hex_d;
        shape_q <= shape_d;
        kw_q    <= kw_d;
        halt_q  <= halt_d;
        boff_q  <= boff_d;
        soff_q  <= soff_d;
        line_q  <= line_d;
        col_q   <= col_d;
        sline_q <= sline_d;
        scol_q  <= scol_d;
      end
    end
  end

endmodule

>>> sv/json_token_lexer_top.sv
// JSON token lexer: takes one document byte per beat and gives one token per output beat,
// each with its kind, start offset, length, line, column and error code, last_of_run marking
// the final token caused by a byte. A byte is registered on acceptance and lexed, once the queue has
// room, into a four-entry token queue whose head drives the output; its first token is
// visible once written into the queue. One byte is taken every cycle while the queue holds at most
// one token, so with tokens drained as they appear the rate is one byte per clock; a byte
// that leaves two or three tokens (a word ending on a delimiter, or the end of the document)
// holds input back while the queue drains. No clearing pass after reset.
module json_token_lexer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_document_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_kind_o,
  output logic [19:0] token_start_o,
  output logic [20:0] token_length_o,
  output logic [20:0] line_number_o,
  output logic [20:0] column_number_o,
  output logic [2:0]  error_code_o,
  output logic        last_of_run_o
);

  jtl_pkg::push_t  push;
  jtl_pkg::token_t head;
  logic            room;

  jtl_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .end_of_document_i (end_of_document_i),
    .room_i            (room),
    .push_o            (push)
  );

  jtl_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign token_kind_o    = head.kind;
  assign token_start_o   = head.start;
  assign token_length_o  = head.length;
  assign line_number_o   = head.line;
  assign column_number_o = head.column;
  assign error_code_o    = head.err;
  assign last_of_run_o   = head.last;

endmodule

>>> sv/jtl_checker.sv
`include "json_token_lexer_top_macros.svh"

module jtl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [3:0]  token_kind_i,
  input logic [19:0] token_start_i,
  input logic [20:0] token_length_i,
  input logic [20:0] line_number_i,
  input logic [20:0] column_number_i,
  input logic [2:0]  error_code_i,
  input logic        last_of_run_i
);

  logic end_beat;
  assign end_beat = out_valid_i && (token_kind_i == jtl_pkg::TK_END);

  // a stalled output beat holds
  `JTL_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable({token_kind_i, token_start_i, token_length_i, line_number_i, column_number_i, error_code_i, last_of_run_i}))

  // the end token closes the run of its byte and is empty
  `JTL_ASSERT_IMPL(a_end_last, end_beat, last_of_run_i && token_length_i == '0)

  // error code is set exactly on error tokens
  `JTL_ASSERT_IMPL(a_err_code, out_valid_i, (token_kind_i == jtl_pkg::TK_ERROR) == (error_code_i != jtl_pkg::ERR_NONE))

  // delimiters are always one byte long
  `JTL_ASSERT_IMPL(a_delim_len, out_valid_i && token_kind_i <= jtl_pkg::TK_COMMA, token_length_i == 21'd1)

endmodule

bind json_token_lexer_top jtl_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .token_kind_i    (token_kind_o),
  .token_start_i   (token_start_o),
  .token_length_i  (token_length_o),
  .line_number_i   (line_number_o),
  .column_number_i (column_number_o),
  .error_code_i    (error_code_o),
  .last_of_run_i   (last_of_run_o)
);
